### src/image_box_downscaler_assert.svh
`ifndef IMAGE_BOX_DOWNSCALER_ASSERT_SVH
`define IMAGE_BOX_DOWNSCALER_ASSERT_SVH

// same-cycle implication
`define IBD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/ibd_pkg.sv
package ibd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_FACTOR = 16;
    localparam int MAX_HEIGHT = 4096;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int FACTOR_W = 5;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int BLK_W  = $clog2(MAX_FACTOR);

    localparam int NUM_CHAN   = 4;
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DIV_STEPS  = CHAN_W;
    localparam int DIVSTEP_W  = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FACTOR = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] chan0_in;
        logic [CHAN_W-1:0] chan1_in;
        logic [CHAN_W-1:0] chan2_in;
        logic [CHAN_W-1:0] chan3_in;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan0_out;
        logic [CHAN_W-1:0] chan1_out;
        logic [CHAN_W-1:0] chan2_out;
        logic [CHAN_W-1:0] chan3_out;
        logic              end_of_row;
        logic              end_of_image;
    } out_word_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [FACTOR_W-1:0] factor;
    } geom_t;

    typedef struct packed {
        logic take;
        logic sum;
        logic div_step;
        logic out_load;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### src/ibd_ram.sv
module ibd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ibd_ctrl.sv
module ibd_ctrl import ibd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    cfg_write,
    input  status_t status,
    output logic    s_ready,
    output cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [DIVSTEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cmd.restart = cfg_write;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.take   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum   = 1'b1;
                step_next = '0;
                state_next = status.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIVSTEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/ibd_datapath.sv
module ibd_datapath import ibd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    input  geom_t     geom,
    input  in_word_t  s_data,
    input  logic      m_ready,
    output status_t   status,
    output logic      m_valid,
    output out_word_t m_data
);

    // position counters
    logic [COL_W-1:0] col_reg, oc_reg;
    logic [ROW_W-1:0] row_reg;
    logic [BLK_W-1:0] cib_reg, rib_reg;

    // latched per-word info
    in_word_t         pix_reg;
    logic             first_reg, emit_reg, last_col_reg, last_row_reg;
    logic [COL_W-1:0] addr_reg;
    logic [CNT_W-1:0] count_reg;

    // divider
    logic [NUM_CHAN-1:0][SUM_W-1:0]  rem_reg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] quo_reg;
    logic [SUM_W-1:0]                dvs_reg;

    logic      m_valid_reg;
    out_word_t m_data_reg;

    logic                            last_col, last_row, cib_end, rib_end;
    logic [FACTOR_W-1:0]             cib_p1, rib_p1;
    logic [2*FACTOR_W-1:0]           prod;
    logic [NUM_CHAN*SUM_W-1:0]       rd_data;
    logic [NUM_CHAN-1:0][SUM_W-1:0]  sum_vec;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_arr;

    assign cib_p1   = FACTOR_W'(cib_reg) + 1'b1;
    assign rib_p1   = FACTOR_W'(rib_reg) + 1'b1;
    assign prod     = cib_p1 * rib_p1;
    assign last_col = (WIDTH_W'(col_reg) + 1'b1) >= geom.width;
    assign last_row = (HEIGHT_W'(row_reg) + 1'b1) >= geom.height;
    assign cib_end  = cib_p1 >= geom.factor;
    assign rib_end  = rib_p1 >= geom.factor;

    assign pix_arr = {pix_reg.chan3_in, pix_reg.chan2_in, pix_reg.chan1_in, pix_reg.chan0_in};

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            sum_vec[c] = (first_reg ? '0 : rd_data[c*SUM_W +: SUM_W])
                       + SUM_W'(pix_arr[c]);
        end
    end

    ibd_ram #(
        .WIDTH (NUM_CHAN * SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .aclk  (aclk),
        .we    (cmd.sum),
        .waddr (addr_reg),
        .wdata (sum_vec),
        .re    (cmd.take),
        .raddr (oc_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            col_reg <= '0;
            row_reg <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            oc_reg  <= '0;
        end else if (cmd.take) begin
            if (last_col) begin
                col_reg <= '0;
                cib_reg <= '0;
                oc_reg  <= '0;
                if (last_row) begin
                    row_reg <= '0;
                    rib_reg <= '0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                    rib_reg <= rib_end ? '0 : rib_reg + 1'b1;
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if (cib_end) begin
                    cib_reg <= '0;
                    oc_reg  <= oc_reg + 1'b1;
                end else begin
                    cib_reg <= cib_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pix_reg      <= s_data;
            first_reg    <= (cib_reg == '0) && (rib_reg == '0);
            emit_reg     <= (last_col || cib_end) && (last_row || rib_end);
            last_col_reg <= last_col;
            last_row_reg <= last_row;
            addr_reg     <= oc_reg;
            count_reg    <= prod[CNT_W-1:0];
        end
    end

    // restoring division, one quotient bit per step on all channels
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            rem_reg <= sum_vec;
            quo_reg <= '0;
            dvs_reg <= SUM_W'(count_reg) << (DIV_STEPS - 1);
        end else if (cmd.div_step) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                if (rem_reg[c] >= dvs_reg) begin
                    rem_reg[c] <= rem_reg[c] - dvs_reg;
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b1};
                end else begin
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b0};
                end
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.chan0_out    <= quo_reg[0];
            m_data_reg.chan1_out    <= quo_reg[1];
            m_data_reg.chan2_out    <= quo_reg[2];
            m_data_reg.chan3_out    <= quo_reg[3];
            m_data_reg.end_of_row   <= last_col_reg;
            m_data_reg.end_of_image <= last_col_reg && last_row_reg;
        end
    end

    assign status.emit     = emit_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

### src/image_box_downscaler.sv
// a closing block runs ST_SUM, ST_DIV, then ST_OUT, which waits for output space
// words are taken only in ST_IDLE, one at a time (8-step shared divider)
// line store read and write-back on separate cycles of the same word
// reset: synchronous active-low aresetn clears counters, control and registers
// to width, height and factor of 1; the line store is not cleared
module image_box_downscaler import ibd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "image_box_downscaler_assert.svh"

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                wr_en, cfg_write;
    logic [1:0]          reg_idx;
    geom_t               geom;
    cmd_t                cmd;
    status_t             status;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT
                                 || reg_idx == REG_FACTOR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
            factor_reg <= FACTOR_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                REG_FACTOR: factor_reg <= pwdata[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_FACTOR: prdata = APB_DATA_W'(factor_reg);
            default:    prdata = '0;
        endcase
    end

    // zero acts as one, oversize saturates
    always_comb begin
        geom.width  = (width_reg == '0) ? WIDTH_W'(1)
                    : (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
        geom.height = (height_reg == '0) ? HEIGHT_W'(1)
                    : (height_reg > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT)
                    : height_reg;
        geom.factor = (factor_reg == '0) ? FACTOR_W'(1)
                    : (factor_reg > FACTOR_W'(MAX_FACTOR)) ? FACTOR_W'(MAX_FACTOR)
                    : factor_reg;
    end

    ibd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .cfg_write (cfg_write),
        .status    (status),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    ibd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .geom    (geom),
        .s_data  (s_data),
        .m_ready (m_ready),
        .status  (status),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    `IBD_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready)
    `IBD_ASSERT_NEXT(a_no_result_after_take, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))
    `IBD_ASSERT_NOW(a_ready_on_new_result, aclk, aresetn, $rose(m_valid), s_ready)
    `IBD_ASSERT_NOW(a_image_end_is_row_end, aclk, aresetn, m_valid && m_data.end_of_image,
                    m_data.end_of_row)

endmodule

### dv/testbench.sv
module testbench;
    import ibd_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum int {PIX_RANDOM, PIX_BRIGHT, PIX_DARK, PIX_MIXED} pix_style_e;

    class box_mean_tracker;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        logic [FACTOR_W-1:0] factor_reg;
        int unsigned         src_col, src_row, col_in_blk, row_in_blk, out_col;
        logic [SUM_W-1:0]    col_sum [MAX_WIDTH][NUM_CHAN];
        out_word_t           pending_means [$];
        int unsigned         mismatches;

        function new();
            width_reg  = 1;
            height_reg = 1;
            factor_reg = 1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            src_col    = 0;
            src_row    = 0;
            col_in_blk = 0;
            row_in_blk = 0;
            out_col    = 0;
        endfunction

        function int unsigned effective(int unsigned v, int unsigned hi);
            return (v == 0) ? 1 : (v > hi) ? hi : v;
        endfunction

        function void configure(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_WIDTH:  width_reg  = value[WIDTH_W-1:0];
                REG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
                REG_FACTOR: factor_reg = value[FACTOR_W-1:0];
                default: return;
            endcase
            restart();
        endfunction

        function int unsigned pending_count();
            return pending_means.size();
        endfunction

        function void take_pixel(in_word_t px);
            int unsigned       w, h, f, oc, count;
            int                c;
            bit                last_col, last_row;
            logic [CHAN_W-1:0] chan [NUM_CHAN];
            logic [CHAN_W-1:0] mean [NUM_CHAN];
            out_word_t         res;
            w = effective(width_reg, MAX_WIDTH);
            h = effective(height_reg, MAX_HEIGHT);
            f = effective(factor_reg, MAX_FACTOR);
            oc = (out_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : out_col;
            last_col = (src_col + 1 >= w);
            last_row = (src_row + 1 >= h);
            chan = '{px.chan0_in, px.chan1_in, px.chan2_in, px.chan3_in};
            // first pixel of a block starts the column sums afresh
            if (col_in_blk == 0 && row_in_blk == 0) begin
                for (c = 0; c < NUM_CHAN; c++) col_sum[oc][c] = '0;
            end
            for (c = 0; c < NUM_CHAN; c++) col_sum[oc][c] += chan[c];
            if ((last_col || col_in_blk + 1 >= f) && (last_row || row_in_blk + 1 >= f)) begin
                count = (col_in_blk + 1) * (row_in_blk + 1);
                for (c = 0; c < NUM_CHAN; c++) mean[c] = CHAN_W'(col_sum[oc][c] / count);
                res.chan0_out    = mean[0];
                res.chan1_out    = mean[1];
                res.chan2_out    = mean[2];
                res.chan3_out    = mean[3];
                res.end_of_row   = last_col;
                res.end_of_image = last_col && last_row;
                pending_means.push_back(res);
            end
            if (last_col) begin
                src_col    = 0;
                col_in_blk = 0;
                out_col    = 0;
                if (last_row) begin
                    src_row    = 0;
                    row_in_blk = 0;
                end else begin
                    src_row++;
                    row_in_blk = (row_in_blk + 1 >= f) ? 0 : row_in_blk + 1;
                end
            end else begin
                src_col++;
                if (col_in_blk + 1 >= f) begin
                    col_in_blk = 0;
                    out_col    = oc + 1;
                end else begin
                    col_in_blk++;
                end
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_mean(out_word_t got);
            out_word_t want;
            if (pending_means.size() == 0) begin
                $error("unexpected output word %h", got);
                mismatches++;
                return;
            end
            want = pending_means.pop_front();
            check_field("chan0_out", want.chan0_out, got.chan0_out);
            check_field("chan1_out", want.chan1_out, got.chan1_out);
            check_field("chan2_out", want.chan2_out, got.chan2_out);
            check_field("chan3_out", want.chan3_out, got.chan3_out);
            check_field("end_of_row", 8'(want.end_of_row), 8'(got.end_of_row));
            check_field("end_of_image", 8'(want.end_of_image), 8'(got.end_of_image));
        endfunction
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    out_word_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    box_mean_tracker tracker = new();

    bit          tx_steady    = 1'b0;
    int unsigned burst_left   = 0;
    bit          rx_steady    = 1'b0;
    int unsigned rx_stall_pct = 30;
    int unsigned rx_hold      = 0;
    int unsigned pixels_sent  = 0;

    image_box_downscaler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver stalls in held runs of random length
    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
        end else if (rx_steady) begin
            m_ready = 1'b1;
        end else begin
            m_ready = ($urandom_range(0, 99) >= rx_stall_pct);
            rx_hold = $urandom_range(0, 7);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.compare_mean(m_data);
    end

    task automatic wait_drained();
        s_valid = 1'b0;
        while (tracker.pending_count() != 0) @(negedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (16) @(negedge aclk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        paddr   = {idx, 2'b00};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.configure(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic push_pixel(input in_word_t px);
        s_data  = px;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.take_pixel(px);
        pixels_sent++;
        @(negedge aclk);
        if (!tx_steady) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end else begin
                    s_valid = 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic logic [7:0] make_byte(pix_style_e style);
        case (style)
            PIX_BRIGHT: return 8'hFF;
            PIX_DARK:   return 8'h00;
            PIX_MIXED: begin
                case ($urandom_range(0, 2))
                    0: return 8'h00;
                    1: return 8'hFF;
                    default: return 8'($urandom);
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned f,
                             input int unsigned npix, input pix_style_e style);
        logic [31:0] value;
        in_word_t    px;
        int          spare_at;
        settle();
        tx_steady    = ($urandom_range(0, 3) == 0);
        rx_steady    = ($urandom_range(0, 3) == 0);
        rx_stall_pct = $urandom_range(10, 70);
        value = $urandom;
        value[WIDTH_W-1:0] = WIDTH_W'(w);
        program_reg(REG_WIDTH, value);
        value = $urandom;
        value[HEIGHT_W-1:0] = HEIGHT_W'(h);
        program_reg(REG_HEIGHT, value);
        value = $urandom;
        value[FACTOR_W-1:0] = FACTOR_W'(f);
        program_reg(REG_FACTOR, value);
        // a write to the unused index must leave the image position alone
        spare_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix - 1) : -1;
        for (int i = 0; i < npix; i++) begin
            if (i == spare_at) begin
                settle();
                program_reg(REG_SPARE, $urandom);
            end
            px.chan0_in = make_byte(style);
            px.chan1_in = make_byte(style);
            px.chan2_in = make_byte(style);
            px.chan3_in = make_byte(style);
            push_pixel(px);
        end
    endtask

    initial begin
        int unsigned w, h, f, area, npix;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // reset geometry is one pixel per image
        push_pixel(in_word_t'(32'h0000_0000));
        push_pixel(in_word_t'(32'hFFFF_FFFF));
        push_pixel(in_word_t'(32'hAA55_AA55));
        push_pixel(in_word_t'(32'h55AA_55AA));

        // zero registers act as one
        settle();
        program_reg(REG_WIDTH, 32'h0);
        program_reg(REG_HEIGHT, 32'h0);
        program_reg(REG_FACTOR, 32'h0);
        push_pixel(in_word_t'(32'h1234_5678));

        // 3x3 with factor 2: partial blocks at right and bottom
        settle();
        program_reg(REG_WIDTH, 32'd3);
        program_reg(REG_HEIGHT, 32'd3);
        program_reg(REG_FACTOR, 32'd2);
        push_pixel(in_word_t'(32'hFFFF_FFFF));
        push_pixel(in_word_t'(32'hFEFE_FEFE));
        push_pixel(in_word_t'(32'h0102_0304));
        push_pixel(in_word_t'(32'hFF00_FF00));
        settle();
        program_reg(REG_SPARE, 32'hFFFF_FFFF);
        push_pixel(in_word_t'(32'h00FF_00FF));
        push_pixel(in_word_t'(32'h8080_8080));
        push_pixel(in_word_t'(32'hFFFF_FFFF));
        push_pixel(in_word_t'(32'h0000_0001));
        push_pixel(in_word_t'(32'hFFFF_FFFF));

        settle();
        program_reg(REG_WIDTH, 32'hFFFF_F802);
        program_reg(REG_HEIGHT, 32'hFFFF_E001);
        program_reg(REG_FACTOR, 32'hFFFF_FFE0);
        push_pixel(in_word_t'(32'hDEAD_BEEF));
        push_pixel(in_word_t'(32'hCAFE_F00D));

        settle();
        program_reg(REG_WIDTH, 32'd5);
        program_reg(REG_HEIGHT, 32'd1);
        program_reg(REG_FACTOR, 32'd4);
        repeat (5) push_pixel(in_word_t'(32'hFFFF_FFFF));

        // oversized width, one full row of maximum blocks
        run_phase(2047, 1, 31, MAX_WIDTH, PIX_MIXED);
        // oversized height, a few rows only
        run_phase(1, 8191, MAX_FACTOR, 40, PIX_RANDOM);
        run_phase(7, 5, MAX_FACTOR, 35, PIX_BRIGHT);

        while (pixels_sent < 1925) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
            f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
            area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            npix = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area)
                                               : area * $urandom_range(1, 2);
            run_phase(w, h, f, npix, pix_style_e'($urandom_range(0, 5) > 3 ?
                                                   $urandom_range(1, 3) : 0));
        end

        wait_drained();
        repeat (24) @(negedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
            $display("[image_box_downscaler] OK");
        end else begin
            $display("[image_box_downscaler] ERROR");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("[image_box_downscaler] ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/ibd_pkg.sv
src/ibd_ram.sv
src/ibd_ctrl.sv
src/ibd_datapath.sv
src/image_box_downscaler.sv
dv/testbench.sv
